@@ rtl/core/drc_pkg.sv @@
// Shared types, constants and codes for the differential render compositor.
`default_nettype none

package drc_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PROD_W     = 2 * CHAN_W;
  localparam int unsigned NUM_CHAN   = 3;
  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

  // Quotient bits resolved per divider stage, and the resulting depths.
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = CHAN_W / BITS_PER_STAGE;
  localparam int unsigned LANE_DEPTH     = DIV_STAGES + 2;
  localparam int unsigned RES_LAT        = LANE_DEPTH + 1;

  typedef enum logic [1:0] {
    PATH_WEIGHTED = 2'd0,
    PATH_PASS     = 2'd1,
    PATH_RATIO    = 2'd2
  } path_e;

  typedef struct packed {
    logic [CHAN_W-1:0] scene_r;
    logic [CHAN_W-1:0] scene_g;
    logic [CHAN_W-1:0] scene_b;
    logic [CHAN_W-1:0] local_r;
    logic [CHAN_W-1:0] local_g;
    logic [CHAN_W-1:0] local_b;
    logic [CHAN_W-1:0] geom_r;
    logic [CHAN_W-1:0] geom_g;
    logic [CHAN_W-1:0] geom_b;
    logic [CHAN_W-1:0] geom_mask;
    logic [CHAN_W-1:0] local_mask;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_r;
    logic [CHAN_W-1:0] out_g;
    logic [CHAN_W-1:0] out_b;
    path_e             path_taken;
  } pix_out_t;

  // One channel's operands as seen by a lane.
  typedef struct packed {
    logic [CHAN_W-1:0] scene;
    logic [CHAN_W-1:0] lcl;
    logic [CHAN_W-1:0] geom;
  } lane_in_t;

  // The three candidate results a lane offers to the merge stage.
  typedef struct packed {
    logic [CHAN_W-1:0] wgt;
    logic [CHAN_W-1:0] pass;
    logic [CHAN_W-1:0] ratio;
  } lane_res_t;

endpackage

`default_nettype wire

@@ rtl/core/drc_lane.sv @@
// One channel lane: shared multiplier, divide by 255, and a pipelined ratio divider.
`default_nettype none

module drc_lane (
  input  wire logic                     clk_i,
  input  wire drc_pkg::lane_in_t        in_i,
  input  wire logic [drc_pkg::CHAN_W-1:0] gmask_i,
  output drc_pkg::lane_res_t            res_o
);

  localparam int unsigned W  = drc_pkg::CHAN_W;
  localparam int unsigned PW = drc_pkg::PROD_W;
  localparam int unsigned D  = drc_pkg::DIV_STAGES;
  localparam int unsigned B  = drc_pkg::BITS_PER_STAGE;

  logic [W-1:0]  op_a;
  logic [PW-1:0] prod_d, prod_q;
  logic [W-1:0]  scene1_q, local1_q;

  // The object path and the ratio path never need both products at once.
  always_comb begin
    op_a   = (gmask_i != '0) ? gmask_i : in_i.scene;
    prod_d = {{W{1'b0}}, op_a} * {{W{1'b0}}, in_i.geom};
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    scene1_q <= in_i.scene;
    local1_q <= in_i.lcl;
  end

  logic [PW-1:0] wsum;
  logic [W-1:0]  wgt_q   [D+1];
  logic [W-1:0]  scene_q [D+1];
  logic [W-1:0]  local_q [D+1];
  logic          zero_q  [D+1];
  logic          sat_q   [D+1];
  logic [PW-1:0] rem_q   [D+1];
  logic [W-1:0]  quo_q   [D+1];

  // floor(x/255) = (x + 1 + (x >> 8)) >> 8 for every product of two bytes.
  assign wsum = prod_q + PW'(1) + (prod_q >> W);

  always_ff @(posedge clk_i) begin
    wgt_q[0]   <= wsum[PW-1:W];
    scene_q[0] <= scene1_q;
    local_q[0] <= local1_q;
    zero_q[0]  <= (prod_q == '0);
    sat_q[0]   <= (prod_q[PW-1:W] >= local1_q);
    rem_q[0]   <= prod_q;
    quo_q[0]   <= '0;
  end

  for (genvar k = 0; k < D; k++) begin : g_div
    logic [PW-1:0] rem_d;
    logic [W-1:0]  quo_d;

    // Restoring steps; the remainder stays below divisor << (bit + 1).
    always_comb begin
      logic [PW-1:0] dsh;
      int unsigned   bidx;
      rem_d = rem_q[k];
      quo_d = quo_q[k];
      for (int j = 0; j < B; j++) begin
        bidx = W - 1 - k * B - j;
        dsh  = {{W{1'b0}}, local_q[k]} << bidx;
        if (rem_d >= dsh) begin
          rem_d       = rem_d - dsh;
          quo_d[bidx] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]   <= rem_d;
      quo_q[k+1]   <= quo_d;
      wgt_q[k+1]   <= wgt_q[k];
      scene_q[k+1] <= scene_q[k];
      local_q[k+1] <= local_q[k];
      zero_q[k+1]  <= zero_q[k];
      sat_q[k+1]   <= sat_q[k];
    end
  end

  always_comb begin
    res_o.wgt  = wgt_q[D];
    res_o.pass = scene_q[D];
    if (zero_q[D]) begin
      res_o.ratio = '0;
    end else if (sat_q[D]) begin
      res_o.ratio = drc_pkg::CHAN_MAX;
    end else begin
      res_o.ratio = quo_q[D];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/drc_merge.sv @@
// Merge stage: picks each lane's result by path and registers the output beat.
`default_nettype none

module drc_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire drc_pkg::path_e     path_i,
  input  wire drc_pkg::lane_res_t lane_i [drc_pkg::NUM_CHAN],
  output logic                    done_o,
  output drc_pkg::pix_out_t       res_o
);

  logic [drc_pkg::CHAN_W-1:0] sel [drc_pkg::NUM_CHAN];
  logic                       done_q;
  drc_pkg::pix_out_t          res_d, res_q;

  always_comb begin
    for (int c = 0; c < drc_pkg::NUM_CHAN; c++) begin
      unique case (path_i)
        drc_pkg::PATH_WEIGHTED: sel[c] = lane_i[c].wgt;
        drc_pkg::PATH_PASS:     sel[c] = lane_i[c].pass;
        drc_pkg::PATH_RATIO:    sel[c] = lane_i[c].ratio;
        default:                sel[c] = lane_i[c].ratio;
      endcase
    end
    res_d.out_r      = sel[0];
    res_d.out_g      = sel[1];
    res_d.out_b      = sel[2];
    res_d.path_taken = path_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/core/differential_render_composite_core.sv @@
// Top level of the differential render compositor: lanes, control pipeline, merge.
// Result path: an accepted pixel passes the lane product register, the first divider
//   register, each ratio divider stage and the merge output register before its beat shows on done_o.
// Throughput: one pixel per clock; start_i may be held high every cycle.
// busy_o stays low, since every stage is a fixed pipeline slot and the receiver
//   cannot stall; the depth is set by the four two-bit stages of the ratio divider.
// Reset clears only the valid pipeline; no beat is produced for a pixel in flight.
`default_nettype none

module differential_render_composite_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire drc_pkg::pix_in_t  pix_i,
  output logic                   done_o,
  output drc_pkg::pix_out_t      res_o
);

  localparam int unsigned N = drc_pkg::NUM_CHAN;
  localparam int unsigned L = drc_pkg::LANE_DEPTH;

  // The pipeline has no back pressure, so a new pixel can enter every cycle.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Split the pixel beat into one operand set per color channel.
  drc_pkg::lane_in_t  lane_in  [N];
  drc_pkg::lane_res_t lane_res [N];

  always_comb begin
    lane_in[0] = '{scene: pix_i.scene_r, lcl: pix_i.local_r, geom: pix_i.geom_r};
    lane_in[1] = '{scene: pix_i.scene_g, lcl: pix_i.local_g, geom: pix_i.geom_g};
    lane_in[2] = '{scene: pix_i.scene_b, lcl: pix_i.local_b, geom: pix_i.geom_b};
  end

  for (genvar c = 0; c < N; c++) begin : g_lane
    drc_lane u_lane (
      .clk_i   (clk_i),
      .in_i    (lane_in[c]),
      .gmask_i (pix_i.geom_mask),
      .res_o   (lane_res[c])
    );
  end

  // The path is decided once from the masks and travels beside the lanes.
  // The object mask wins; without it, a clear local mask passes the scene through.
  drc_pkg::path_e path_d;

  always_comb begin
    if (pix_i.geom_mask != '0) begin
      path_d = drc_pkg::PATH_WEIGHTED;
    end else if (pix_i.local_mask == '0) begin
      path_d = drc_pkg::PATH_PASS;
    end else begin
      path_d = drc_pkg::PATH_RATIO;
    end
  end

  logic           vld_q  [L];
  drc_pkg::path_e path_q [L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < L; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int s = 1; s < L; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    path_q[0] <= path_d;
    for (int s = 1; s < L; s++) begin
      path_q[s] <= path_q[s-1];
    end
  end

  // The merge stage lines up with the last divider stage of every lane.
  drc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[L-1]),
    .path_i  (path_q[L-1]),
    .lane_i  (lane_res),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/drc_chk.sv @@
// Port-level checker for the compositor top level, with its bind statement.
`default_nettype none

module drc_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire drc_pkg::pix_in_t  pix_i,
  input wire logic              done_o,
  input wire drc_pkg::pix_out_t res_o
);

  localparam int unsigned LAT = drc_pkg::RES_LAT;

  // Every accepted beat comes back after the fixed pipeline latency.
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##(LAT-1) done_o)
    else $error("accepted pixel did not produce a result beat");

  // No result beat appears without a matching accepted pixel.
  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result beat without an accepted pixel");

  // The object path is reported exactly when the object mask was set.
  a_path_obj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.path_taken == drc_pkg::PATH_WEIGHTED)
                == ($past(pix_i.geom_mask, LAT) != '0)))
    else $error("path does not match the object mask");

  // The passthrough path returns the scene pixel unchanged.
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.path_taken == drc_pkg::PATH_PASS) |->
      (res_o.out_r == $past(pix_i.scene_r, LAT) &&
       res_o.out_g == $past(pix_i.scene_g, LAT) &&
       res_o.out_b == $past(pix_i.scene_b, LAT)))
    else $error("passthrough beat differs from the scene pixel");

endmodule

bind differential_render_composite_core drc_chk u_drc_chk (.*);

`default_nettype wire
